>>> rtl/core/assert_macros.svh
// Assertion macros used by the padder controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rbp_pkg.sv
// Types and constants shared by the replicate border padder modules.
package rbp_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int SIZE_CFG_W  = 9;
  localparam int PAD_CFG_W   = 7;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int SIZE_RST    = 256;

  // Word kinds carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BOTTOM   = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic load_we;   // write the incoming word and advance the load position
    logic emit_rd;   // read the source sample and advance the emit position
    logic out_load;  // move the read data into the output register
  } rbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
  } rbp_sts_t;

endpackage

>>> rtl/core/rbp_ctrl.sv
// Controller state machine of the replicate border padder.
`include "assert_macros.svh"

module rbp_ctrl import rbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_op,
  output logic     in_tready,
  output rbp_cmd_t cmd,
  input  rbp_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t st_r, st_nxt;

  assign in_tready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt       = st_r;
    cmd.load_we  = 1'b0;
    cmd.emit_rd  = 1'b0;
    cmd.out_load = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_EMIT) begin
            cmd.emit_rd = 1'b1;
            st_nxt      = ST_READ;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      ST_READ: begin
        // hold the read word until the output register can take it
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  `ASSERT_RST(a_emit_enters_read,
    (st_r == ST_IDLE && in_tvalid && in_op == OP_EMIT) |=> (st_r == ST_READ),
    "emit word did not start a store read")
  `ASSERT_RST(a_load_only_when_free, cmd.out_load |-> sts.out_free,
    "output register overwritten while full")
  `ASSERT_RST(a_read_holds,
    (st_r == ST_READ && !sts.out_free) |=> (st_r == ST_READ && !in_tready),
    "pending read word dropped during output stall")

endmodule

>>> rtl/core/rbp_dp.sv
// Datapath of the replicate border padder: config, positions, frame store, output register.
module rbp_dp import rbp_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_PAD     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rbp_cmd_t              cmd,
  output rbp_sts_t              sts,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample,
  output logic                  out_last
);

  localparam int COL_IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLS_W    = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
  localparam int PAD_W     = (MAX_PAD > 0) ? $clog2(MAX_PAD + 1) : 1;
  localparam int EXT_C_W   = $clog2(2 * MAX_PAD + MAX_COLUMNS + 1);
  localparam int EXT_R_W   = $clog2(2 * MAX_PAD + MAX_ROWS + 1);
  localparam int DEPTH     = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COLS_RST  = (SIZE_RST > MAX_COLUMNS) ? MAX_COLUMNS : SIZE_RST;
  localparam int ROWS_RST  = (SIZE_RST > MAX_ROWS) ? MAX_ROWS : SIZE_RST;

  // Clamped configuration
  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] rows_r;
  logic [PAD_W-1:0]  pl_r, pr_r, pt_r, pb_r;

  logic [SIZE_CFG_W-1:0] cfg_size;
  logic [PAD_CFG_W-1:0]  cfg_pad;
  logic [COLS_W-1:0]     cfg_cols;
  logic [ROWS_W-1:0]     cfg_rows;
  logic [PAD_W-1:0]      cfg_pad_cl;

  assign cfg_size = cfg_wdata[SIZE_CFG_W-1:0];
  assign cfg_pad  = cfg_wdata[PAD_CFG_W-1:0];

  always_comb begin
    if (cfg_size == '0) begin
      cfg_cols = COLS_W'(1);
      cfg_rows = ROWS_W'(1);
    end else begin
      cfg_cols = (32'(cfg_size) > MAX_COLUMNS) ? COLS_W'(MAX_COLUMNS) : COLS_W'(cfg_size);
      cfg_rows = (32'(cfg_size) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : ROWS_W'(cfg_size);
    end
    cfg_pad_cl = (32'(cfg_pad) > MAX_PAD) ? PAD_W'(MAX_PAD) : PAD_W'(cfg_pad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_W'(COLS_RST);
      rows_r <= ROWS_W'(ROWS_RST);
      pl_r   <= '0;
      pr_r   <= '0;
      pt_r   <= '0;
      pb_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLUMNS: cols_r <= cfg_cols;
        REG_GRID_ROWS:    rows_r <= cfg_rows;
        REG_PAD_LEFT:     pl_r   <= cfg_pad_cl;
        REG_PAD_RIGHT:    pr_r   <= cfg_pad_cl;
        REG_PAD_TOP:      pt_r   <= cfg_pad_cl;
        REG_PAD_BOTTOM:   pb_r   <= cfg_pad_cl;
        default: ;
      endcase
    end
  end

  // Load position
  logic [ROW_IDX_W-1:0] load_row_r, load_row_nxt, lrow;
  logic [COL_IDX_W-1:0] load_col_r, load_col_nxt, lcol;
  logic [ROWS_W-1:0]    lrow_inc;
  logic [COLS_W-1:0]    lcol_inc;
  logic [ADDR_W-1:0]    waddr;

  always_comb begin
    // restart a position that the current grid no longer holds
    lrow = (ROWS_W'(load_row_r) >= rows_r) ? '0 : load_row_r;
    lcol = (COLS_W'(load_col_r) >= cols_r) ? '0 : load_col_r;
    lrow_inc = ROWS_W'(lrow) + ROWS_W'(1);
    lcol_inc = COLS_W'(lcol) + COLS_W'(1);
    if (lrow_inc >= rows_r) begin
      load_row_nxt = '0;
      load_col_nxt = (lcol_inc >= cols_r) ? '0 : COL_IDX_W'(lcol_inc);
    end else begin
      load_row_nxt = ROW_IDX_W'(lrow_inc);
      load_col_nxt = lcol;
    end
    waddr = ADDR_W'(ADDR_W'(lcol) * ADDR_W'(MAX_ROWS) + ADDR_W'(lrow));
  end

  // Emit position over the padded grid
  logic [EXT_R_W-1:0]   emit_row_r, emit_row_nxt, erow, height, erow_inc, drow;
  logic [EXT_C_W-1:0]   emit_col_r, emit_col_nxt, ecol, width, ecol_inc, dcol;
  logic [ROW_IDX_W-1:0] src_row;
  logic [COL_IDX_W-1:0] src_col;
  logic                 is_last;
  logic [ADDR_W-1:0]    raddr;

  always_comb begin
    height   = EXT_R_W'(pt_r) + EXT_R_W'(rows_r) + EXT_R_W'(pb_r);
    width    = EXT_C_W'(pl_r) + EXT_C_W'(cols_r) + EXT_C_W'(pr_r);
    erow     = (emit_row_r >= height) ? '0 : emit_row_r;
    ecol     = (emit_col_r >= width) ? '0 : emit_col_r;
    drow     = erow - EXT_R_W'(pt_r);
    dcol     = ecol - EXT_C_W'(pl_r);
    // clamp to the nearest edge sample
    if (erow < EXT_R_W'(pt_r)) begin
      src_row = '0;
    end else if (drow >= EXT_R_W'(rows_r)) begin
      src_row = ROW_IDX_W'(rows_r - ROWS_W'(1));
    end else begin
      src_row = ROW_IDX_W'(drow);
    end
    if (ecol < EXT_C_W'(pl_r)) begin
      src_col = '0;
    end else if (dcol >= EXT_C_W'(cols_r)) begin
      src_col = COL_IDX_W'(cols_r - COLS_W'(1));
    end else begin
      src_col = COL_IDX_W'(dcol);
    end
    is_last  = (erow == height - EXT_R_W'(1)) && (ecol == width - EXT_C_W'(1));
    erow_inc = erow + EXT_R_W'(1);
    ecol_inc = ecol + EXT_C_W'(1);
    if (erow_inc >= height) begin
      emit_row_nxt = '0;
      emit_col_nxt = (ecol_inc >= width) ? '0 : ecol_inc;
    end else begin
      emit_row_nxt = erow_inc;
      emit_col_nxt = ecol;
    end
    raddr = ADDR_W'(ADDR_W'(src_col) * ADDR_W'(MAX_ROWS) + ADDR_W'(src_row));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else begin
      if (cmd.load_we) begin
        load_row_r <= load_row_nxt;
        load_col_r <= load_col_nxt;
      end
      if (cmd.emit_rd) begin
        emit_row_r <= emit_row_nxt;
        emit_col_r <= emit_col_nxt;
      end
    end
  end

  // Frame store, one write or one registered read per cycle
  logic [SAMPLE_W-1:0] frame_mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      frame_mem[waddr] <= in_sample;
    end
    if (cmd.emit_rd) begin
      rd_data_r <= frame_mem[raddr];
      rd_last_r <= is_last;
    end
  end

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_last_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= rd_data_r;
      out_last_r   <= rd_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/core/replicate_border_padder.sv
// Top level of the replicate border padder.
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid / tready    tdata = sample, tuser = op
//   out_     master     tvalid / tready    tdata = sample, tlast = final word
//   cfg_     write      we                 index, wdata
//
// A load word is written into the frame store as it is taken; the block can take
// the next word straight after. An emit word first reads the frame store into a
// registered read word, then moves the sample into the output register; a stalled output holds it.
// The frame store is not cleared by reset; only counters, config, state and output valid reset.
// A load word is still taken while a finished sample waits on the output.
module replicate_border_padder import rbp_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int MAX_PAD     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] in_sample
  input  logic                  in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // [31:0] out_sample
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rbp_cmd_t cmd;
  rbp_sts_t sts;

  rbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rbp_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_PAD     (MAX_PAD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

>>> tb/sv/replicate_border_padder_tb.sv
// Self-checking stream testbench for the replicate border padder.
package rbp_tb_pkg;
  import rbp_pkg::*;

  localparam int GRID_COLS_MAX = 256;
  localparam int GRID_ROWS_MAX = 256;
  localparam int PAD_MAX       = 64;
  localparam int STORE_WORDS   = GRID_COLS_MAX * GRID_ROWS_MAX;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } padded_word_t;

  class padding_scoreboard;
    bit [SAMPLE_W-1:0]   frame_mem [STORE_WORDS];
    bit                  loaded [STORE_WORDS];
    int unsigned         load_row, load_col, emit_row, emit_col;
    bit [SIZE_CFG_W-1:0] cols_reg, rows_reg;
    bit [PAD_CFG_W-1:0]  left_reg, right_reg, top_reg, bottom_reg;
    padded_word_t        pending_samples[$];
    int unsigned         errors, loads_taken, emits_taken, frames_closed, reg_writes;

    function new();
      cols_reg = SIZE_CFG_W'(SIZE_RST);
      rows_reg = SIZE_CFG_W'(SIZE_RST);
    endfunction

    function int unsigned eff_size(bit [SIZE_CFG_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      return (v > limit) ? limit : v;
    endfunction

    function int unsigned eff_pad(bit [PAD_CFG_W-1:0] v);
      return (v > PAD_MAX) ? PAD_MAX : v;
    endfunction

    function int unsigned grid_cols();
      return eff_size(cols_reg, GRID_COLS_MAX);
    endfunction

    function int unsigned grid_rows();
      return eff_size(rows_reg, GRID_ROWS_MAX);
    endfunction

    function int unsigned padded_width();
      return eff_pad(left_reg) + grid_cols() + eff_pad(right_reg);
    endfunction

    function int unsigned padded_height();
      return eff_pad(top_reg) + grid_rows() + eff_pad(bottom_reg);
    endfunction

    // Map a padded coordinate back onto the grid, pinning it to the nearest edge.
    function int unsigned clamp_coord(int unsigned p, int unsigned lead, int unsigned size);
      if (p < lead) return 0;
      if (p - lead >= size) return size - 1;
      return p - lead;
    endfunction

    // Store address the next emit will read; positions off the grid restart at zero.
    function int unsigned emit_source();
      int unsigned r, c;
      r = (emit_row >= padded_height()) ? 0 : emit_row;
      c = (emit_col >= padded_width()) ? 0 : emit_col;
      return clamp_coord(c, eff_pad(left_reg), grid_cols()) * GRID_ROWS_MAX
           + clamp_coord(r, eff_pad(top_reg), grid_rows());
    endfunction

    function bit emit_is_safe();
      return loaded[emit_source()];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_GRID_COLUMNS: cols_reg = val;
        REG_GRID_ROWS:    rows_reg = val;
        REG_PAD_LEFT:     left_reg = val[PAD_CFG_W-1:0];
        REG_PAD_RIGHT:    right_reg = val[PAD_CFG_W-1:0];
        REG_PAD_TOP:      top_reg = val[PAD_CFG_W-1:0];
        REG_PAD_BOTTOM:   bottom_reg = val[PAD_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic op, logic [SAMPLE_W-1:0] data);
      int unsigned addr;
      padded_word_t w;
      if (op == OP_LOAD) begin
        if (load_row >= grid_rows()) load_row = 0;
        if (load_col >= grid_cols()) load_col = 0;
        addr = load_col * GRID_ROWS_MAX + load_row;
        frame_mem[addr] = data;
        loaded[addr] = 1'b1;
        loads_taken++;
        load_row++;
        if (load_row >= grid_rows()) begin
          load_row = 0;
          load_col++;
          if (load_col >= grid_cols()) load_col = 0;
        end
      end else begin
        if (emit_row >= padded_height()) emit_row = 0;
        if (emit_col >= padded_width()) emit_col = 0;
        w.sample = frame_mem[emit_source()];
        w.last = (emit_row == padded_height() - 1) && (emit_col == padded_width() - 1);
        pending_samples.push_back(w);
        emits_taken++;
        emit_row++;
        if (emit_row >= padded_height()) begin
          emit_row = 0;
          emit_col++;
          if (emit_col >= padded_width()) emit_col = 0;
        end
      end
    endfunction

    function void check_word(logic [SAMPLE_W-1:0] sample, logic last);
      padded_word_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word: expected none, got sample %h last %b",
                 $time, sample, last);
        return;
      end
      want = pending_samples.pop_front();
      if (sample !== want.sample) begin
        errors++;
        $display("%0t: sample mismatch: expected %h, got %h", $time, want.sample, sample);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last flag mismatch: expected %b, got %b", $time, want.last, last);
      end
      if (want.last) frames_closed++;
    endfunction
  endclass

endpackage

module replicate_border_padder_tb import rbp_pkg::*, rbp_tb_pkg::*;;

  localparam int ITEM_TARGET   = 1700;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_ALTERNATE} ready_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SAMPLE_W-1:0]   out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  padding_scoreboard sb = new();
  int unsigned burst_left = 0;

  replicate_border_padder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("replicate_border_padder test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
  end

  // Receiver back-pressure: switch at random between ready patterns.
  initial begin
    ready_mode_t mode;
    int unsigned span;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = ready_mode_t'($urandom_range(READY_ALTERNATE, READY_ALWAYS));
      span = $urandom_range(80, 10);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          READY_ALWAYS:    out_tready <= 1'b1;
          READY_COIN:      out_tready <= 1'($urandom_range(1, 0));
          READY_SPARSE:    out_tready <= ($urandom_range(3, 0) == 0);
          READY_ALTERNATE: out_tready <= ~out_tready;
          default:         out_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word, bursting with random gaps, and hold it until taken.
  task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(3, 0) == 0) begin
        burst_left = $urandom_range(120, 40);
        gap = 0;
      end else begin
        burst_left = $urandom_range(16, 1);
        gap = $urandom_range(6, 1);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_word(op, data);
  endtask

  // Hold off the sender until every pending sample is out, then let loads settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] cols, rows, left, right, top, bottom);
    wait_drained();
    if ($urandom_range(3, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                CFG_DATA_W'($urandom()));
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_PAD_LEFT, left);
    write_reg(REG_PAD_RIGHT, right);
    write_reg(REG_PAD_TOP, top);
    write_reg(REG_PAD_BOTTOM, bottom);
    cfg_we <= 1'b0;
  endtask

  // Optionally fill the grid, then emit, with stray loads mixed in as noise.
  task automatic play_phase(input int unsigned emit_count, input bit fill_grid,
                            input int unsigned noise_pct);
    int unsigned grid_words;
    if (fill_grid) begin
      grid_words = sb.grid_cols() * sb.grid_rows();
      repeat (grid_words) send_word(OP_LOAD, random_sample());
    end
    repeat (emit_count) begin
      if ($urandom_range(199, 0) == 0) wait_drained();
      // never read a store entry that has not been loaded
      while ($urandom_range(99, 0) < noise_pct || !sb.emit_is_safe())
        send_word(OP_LOAD, random_sample());
      send_word(OP_EMIT, $urandom());
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    return ($urandom_range(7, 0) == 0) ? '0 : CFG_DATA_W'($urandom_range(6, 1));
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] cols, rows, left, right, top, bottom;
    int unsigned frame_words;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOAD;
    cfg_we    <= 1'b0;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // 2x2 grid with one-sample borders: corners, edges and wrap after the last word
    configure(9'd2, 9'd2, 9'd1, 9'd1, 9'd1, 9'd1);
    send_word(OP_LOAD, 32'h0000_0000);
    send_word(OP_LOAD, 32'hFFFF_FFFF);
    send_word(OP_LOAD, 32'h5555_5555);
    send_word(OP_LOAD, 32'hAAAA_AAAA);
    repeat (17) send_word(OP_EMIT, $urandom());

    // zero sizes act as one; stale emit position restarts; load wraps over the grid
    configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    send_word(OP_LOAD, 32'h8000_0001);
    send_word(OP_EMIT, $urandom());
    send_word(OP_LOAD, 32'h7FFF_FFFE);
    send_word(OP_EMIT, $urandom());

    // size and pad extremes, oversize writes clamped
    configure(9'h1FF, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0);
    play_phase(256, 1'b1, 0);
    configure(9'd1, 9'd256, 9'd0, 9'd0, 9'd0, 9'd0);
    play_phase(40, 1'b1, 5);
    configure(9'd1, 9'd1, 9'h17F, 9'd64, 9'd0, 9'd0);
    play_phase(129, 1'b1, 0);
    configure(9'd1, 9'd1, 9'd0, 9'd0, 9'd64, 9'd127);
    play_phase(129, 1'b1, 0);

    while (sb.loads_taken + sb.emits_taken < ITEM_TARGET) begin
      cols   = pick_size();
      rows   = pick_size();
      left   = CFG_DATA_W'($urandom_range(3, 0));
      right  = CFG_DATA_W'($urandom_range(3, 0));
      top    = CFG_DATA_W'($urandom_range(3, 0));
      bottom = CFG_DATA_W'($urandom_range(3, 0));
      configure(cols, rows, left, right, top, bottom);
      frame_words = sb.padded_width() * sb.padded_height();
      play_phase($urandom_range(2 * frame_words + 2, 1), $urandom_range(4, 0) != 0, 10);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d loads, %0d emits and %0d register writes;",
             sb.loads_taken, sb.emits_taken, sb.reg_writes);
    $display("%0d padded frames closed with the last flag.", sb.frames_closed);
    if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
      $display("replicate_border_padder test passed");
    end else begin
      $display("replicate_border_padder test failed");
    end
    $finish;
  end

endmodule
